/* hdl/atrf_pkg.sv */
`default_nettype none

package atrf_pkg;

  // Field widths
  localparam int ByteW   = 8;
  localparam int MacW    = 64;
  localparam int NetW    = 16;
  localparam int CfgIdxW = 2;
  localparam int TotalW  = 9;
  localparam int StepW   = 5;

  // Frame constants
  localparam logic [ByteW-1:0]  Delimiter      = 8'h7E;
  localparam logic [ByteW-1:0]  FrameType      = 8'h10;
  localparam logic [ByteW-1:0]  CsumBase       = 8'hFF;
  localparam logic [ByteW-1:0]  ZeroByte       = 8'h00;
  localparam logic [ByteW-1:0]  MaxPayload     = 8'd255;
  localparam logic [TotalW-1:0] LenOverhead    = 9'd14;
  localparam logic [NetW-1:0]   NetAddrDefault = 16'hFFFE;

  // Register reset values
  localparam logic [MacW-1:0] DestMacReset = 64'h0000_0000_0000_FFFF;
  localparam logic [NetW-1:0] DestNetReset = 16'hFFFE;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEST_MAC = 2'd0,
    CFG_DEST_NET = 2'd1
  } cfg_idx_e;

  // Position within the emitted sequence for one item
  typedef enum logic [StepW-1:0] {
    STEP_DELIM   = 5'd0,
    STEP_LEN_HI  = 5'd1,
    STEP_LEN_LO  = 5'd2,
    STEP_TYPE    = 5'd3,
    STEP_IDENT   = 5'd4,
    STEP_MAC7    = 5'd5,
    STEP_MAC6    = 5'd6,
    STEP_MAC5    = 5'd7,
    STEP_MAC4    = 5'd8,
    STEP_MAC3    = 5'd9,
    STEP_MAC2    = 5'd10,
    STEP_MAC1    = 5'd11,
    STEP_MAC0    = 5'd12,
    STEP_ADDR_HI = 5'd13,
    STEP_ADDR_LO = 5'd14,
    STEP_RADIUS  = 5'd15,
    STEP_OPTIONS = 5'd16,
    STEP_PAYLOAD = 5'd17,
    STEP_CSUM    = 5'd18
  } step_e;

  // Everything the header byte selector needs
  typedef struct packed {
    step_e             step;
    logic [ByteW-1:0]  count;
    logic [ByteW-1:0]  ident;
    logic [MacW-1:0]   mac;
    logic [NetW-1:0]   net_addr;
  } hdr_t;

endpackage

`default_nettype wire

/* hdl/api_tx_request_framer.sv */
`default_nettype none

// Transmit-request framer. Each input item is one payload byte; an item with
// first_byte_i set opens a frame and produces the 17-byte header, the byte
// itself and, for a one-byte frame, the checksum (up to 19 output items).
// Later payload bytes pass through at one item per cycle while out_stall_i is low;
// the last one is followed by the checksum item marked by end_of_frame_o. Bytes
// with first_byte_i low while no frame is open are dropped without output.
// The block has one item register feeding one output register and emits one
// frame byte per cycle unless out_stall_i holds it, so in_stall_o stays high
// through a header burst and during a checksum; otherwise, with no output stall,
// an item is taken every cycle. Configuration (index 0 destination MAC, 1 network
// address) is always ready and must be written only while the block is idle.
module api_tx_request_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Payload byte stream
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [atrf_pkg::ByteW-1:0]    payload_byte_i,
  input  logic                          first_byte_i,
  input  logic [atrf_pkg::ByteW-1:0]    payload_len_i,
  input  logic [atrf_pkg::ByteW-1:0]    frame_ident_i,
  // Frame byte stream
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [atrf_pkg::ByteW-1:0]    frame_byte_o,
  output logic                          end_of_frame_o,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [atrf_pkg::MacW-1:0]     cfg_data_i
);
  import atrf_pkg::*;

  // Item register
  logic             item_vld_q, item_vld_d;
  logic [ByteW-1:0] item_byte_q;
  logic [ByteW-1:0] item_len_q;
  logic [ByteW-1:0] item_ident_q;
  step_e            step_q, step_d;

  // Frame state and configuration
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic             open_q, open_d;
  logic [MacW-1:0]  mac_q;
  logic [NetW-1:0]  net_q;

  // Output register
  logic             out_vld_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_eof_q;

  logic             item_load;
  logic             out_free;
  logic             emit;
  logic             last;
  logic             advance;
  logic             done;
  logic [ByteW-1:0] count;
  logic [ByteW-1:0] rem_after;
  logic [ByteW-1:0] hdr_byte;
  logic [ByteW-1:0] byte_sel;
  logic             eof_sel;
  hdr_t             hdr;

  assign cfg_ready_o = 1'b1;

  // Clamp the payload count to 1..MaxPayload
  always_comb begin
    count = item_len_q;
    if (item_len_q == '0) begin
      count = ByteW'(1);
    end else if (item_len_q > MaxPayload) begin
      count = MaxPayload;
    end
  end

  assign hdr = '{step: step_q, count: count, ident: item_ident_q,
                 mac: mac_q, net_addr: net_q};

  atrf_hdr_sel u_hdr_sel (
    .hdr_i  (hdr),
    .byte_o (hdr_byte)
  );

  assign out_free  = !out_vld_q || !out_stall_i;
  assign rem_after = (rem_q == '0) ? '0 : rem_q - ByteW'(1);

  // Sequencer: next step, frame state and the byte for this cycle
  always_comb begin
    step_d   = step_q;
    sum_d    = sum_q;
    rem_d    = rem_q;
    open_d   = open_q;
    emit     = 1'b1;
    last     = 1'b0;
    byte_sel = hdr_byte;
    eof_sel  = 1'b0;

    case (step_q)
      STEP_PAYLOAD: begin
        emit     = open_q;
        byte_sel = item_byte_q;
        last     = !open_q || (rem_after != '0);
      end
      STEP_CSUM: begin
        byte_sel = CsumBase - sum_q;
        eof_sel  = 1'b1;
        last     = 1'b1;
      end
      default: begin
        emit = 1'b1;
      end
    endcase

    advance = item_vld_q && (out_free || !emit);
    done    = advance && last;

    if (advance) begin
      if (!last) begin
        step_d = step_e'(5'(step_q) + 5'd1);
      end
      case (step_q)
        STEP_DELIM: begin
          sum_d  = '0;
          rem_d  = count;
          open_d = 1'b1;
        end
        STEP_PAYLOAD: begin
          if (open_q) begin
            sum_d = sum_q + item_byte_q;
            rem_d = rem_after;
          end
        end
        STEP_CSUM: begin
          open_d = 1'b0;
        end
        default: begin
          if (step_q inside {[STEP_TYPE:STEP_OPTIONS]}) begin
            sum_d = sum_q + hdr_byte;
          end
        end
      endcase
    end
  end

  // Input handshake: take a new item once the current one is finished
  assign in_stall_o = item_vld_q && !done;
  assign item_load  = in_valid_i && !in_stall_o;

  always_comb begin
    item_vld_d = item_vld_q;
    if (item_load) begin
      item_vld_d = 1'b1;
    end else if (done) begin
      item_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      step_q     <= STEP_DELIM;
      sum_q      <= '0;
      rem_q      <= '0;
      open_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      mac_q      <= DestMacReset;
      net_q      <= DestNetReset;
    end else begin
      item_vld_q <= item_vld_d;
      sum_q      <= sum_d;
      rem_q      <= rem_d;
      open_q     <= open_d;
      // First-byte items always open a frame at the delimiter step
      if (item_load) begin
        step_q <= first_byte_i ? STEP_DELIM : STEP_PAYLOAD;
      end else begin
        step_q <= step_d;
      end
      if (out_free) begin
        out_vld_q <= item_vld_q && emit;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DEST_MAC: mac_q <= cfg_data_i;
          CFG_DEST_NET: net_q <= cfg_data_i[NetW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_byte_q  <= payload_byte_i;
      item_len_q   <= payload_len_i;
      item_ident_q <= frame_ident_i;
    end
    if (advance && emit) begin
      out_byte_q <= byte_sel;
      out_eof_q  <= eof_sel;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign frame_byte_o   = out_byte_q;
  assign end_of_frame_o = out_eof_q;

endmodule

`default_nettype wire

/* hdl/atrf_hdr_sel.sv */
`default_nettype none

module atrf_hdr_sel (
  input  atrf_pkg::hdr_t                 hdr_i,
  output logic [atrf_pkg::ByteW-1:0]     byte_o
);
  import atrf_pkg::*;

  logic [TotalW-1:0] total;
  logic [NetW-1:0]   addr;
  logic [2:0]        mac_idx;

  // Length field covers frame type through the payload
  assign total   = LenOverhead + {1'b0, hdr_i.count};
  // Zero network address goes out as the default
  assign addr    = (hdr_i.net_addr == '0) ? NetAddrDefault : hdr_i.net_addr;
  // MAC goes out high byte first
  assign mac_idx = 3'(5'(STEP_MAC0) - 5'(hdr_i.step));

  always_comb begin
    byte_o = ZeroByte;
    if (hdr_i.step inside {[STEP_MAC7:STEP_MAC0]}) begin
      byte_o = hdr_i.mac[{mac_idx, 3'b000} +: ByteW];
    end else begin
      case (hdr_i.step)
        STEP_DELIM:   byte_o = Delimiter;
        STEP_LEN_HI:  byte_o = ByteW'(total >> ByteW);
        STEP_LEN_LO:  byte_o = total[ByteW-1:0];
        STEP_TYPE:    byte_o = FrameType;
        STEP_IDENT:   byte_o = hdr_i.ident;
        STEP_ADDR_HI: byte_o = addr[NetW-1:ByteW];
        STEP_ADDR_LO: byte_o = addr[ByteW-1:0];
        default:      byte_o = ZeroByte;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/atrf_checker.sv */
`default_nettype none

module atrf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [atrf_pkg::ByteW-1:0]    payload_byte_i,
  input logic                          first_byte_i,
  input logic [atrf_pkg::ByteW-1:0]    payload_len_i,
  input logic [atrf_pkg::ByteW-1:0]    frame_ident_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [atrf_pkg::ByteW-1:0]    frame_byte_o,
  input logic                          end_of_frame_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [atrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [atrf_pkg::MacW-1:0]     cfg_data_i
);

  // A stalled output item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled output item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(frame_byte_o) && $stable(end_of_frame_o))
    else $error("output payload changed while stalled");

  // A first byte starts a header burst, so the input is held off next cycle
  a_hdr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && first_byte_i |=> in_stall_o)
    else $error("input not held off during header");

  // Two checksum items never follow each other
  a_eof_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && end_of_frame_o |=> !(out_valid_o && end_of_frame_o))
    else $error("back-to-back end of frame");

  // Configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

endmodule

bind api_tx_request_framer atrf_checker u_atrf_checker (.*);

`default_nettype wire
